// ===== sv/asvar_pkg.sv =====
// Shared types and constants for the additive synth voice block.
// No dependencies.
package asvar_pkg;

  localparam int PHASE_W = 32;
  localparam int STEP_W  = 30;
  localparam int AGE_W   = 16;
  localparam int LEN_W   = 15;
  localparam int VOL_W   = 16;
  localparam int SMP_W   = 16;
  localparam int ENV_W   = 17;
  localparam int VSEL_W  = 4;
  localparam int QUOT_W  = 17;
  localparam int NUM_W   = 32;
  localparam int W_W     = 20;

  localparam logic [AGE_W-1:0] AGE_SILENT = 16'hFFFF;
  localparam logic [ENV_W-1:0] ENV_ONE    = 17'd32768;
  localparam logic [63:0]      HALF_PI_Q30 = 64'd1686629713;

  // item kinds on the input selector
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_NOTE   = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_ATTACK = 2'd0;
  localparam logic [1:0] REG_DECAY  = 2'd1;
  localparam logic [1:0] REG_VOLUME = 2'd2;

  typedef struct packed {
    logic                is_note;
    logic [VSEL_W-1:0]   voice;
    logic [STEP_W-1:0]   step;
  } queue_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] attack_len;
    logic [LEN_W-1:0] decay_len;
    logic [VOL_W-1:0] volume;
  } cfg_t;

endpackage

// ===== sv/asvar_front.sv =====
// Front end: accepts input transfers, drops note hits on absent voices,
// and queues the rest for the back end. Depends on asvar_pkg.
module asvar_front import asvar_pkg::*; #(
  parameter int VOICES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [VSEL_W-1:0] in_voice,
  input  logic [STEP_W-1:0] in_step,
  output logic              q_valid,
  input  logic              q_pop,
  output queue_item_t       q_item
);

  queue_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       keep;
  logic       pop;

  // a note hit beyond the last voice is consumed and dropped
  assign keep     = (in_func == FUNC_SAMPLE) || (32'(in_voice) < 32'(VOICES));
  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{is_note: (in_func == FUNC_NOTE), voice: in_voice, step: in_step};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/asvar_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on asvar_pkg.
module asvar_div import asvar_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [LEN_W-1:0]  den,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  logic [NUM_W-1:0] dvd;
  logic [NUM_W-1:0] q;
  logic [LEN_W:0]   rem;
  logic [4:0]       cnt;
  logic             busy;
  logic [LEN_W+1:0] trial;
  logic [LEN_W+1:0] diff;

  assign trial = {rem, dvd[NUM_W-1]};
  assign diff  = trial - {2'b00, den};
  assign quot  = q[QUOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= num;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      dvd <= {dvd[NUM_W-2:0], 1'b0};
      if (!diff[LEN_W+1]) begin
        rem <= diff[LEN_W:0];
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[LEN_W:0];
        q   <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== sv/asvar_back.sv =====
// Back end: voice state memories, harmonic sum, envelope, mix, output register.
// Depends on asvar_pkg and asvar_div.
module asvar_back import asvar_pkg::*; #(
  parameter int VOICES       = 16,
  parameter int SINE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              q_valid,
  output logic              q_pop,
  input  queue_item_t       q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SMP_W-1:0]  out_sample,
  output logic              out_clipped
);

  localparam int VA    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int IW    = $clog2(SINE_ENTRIES);
  localparam int PW    = W_W + ENV_W + 1;
  localparam int ACC_W = PW + VA + 1;
  localparam int MAG_W = ACC_W - 1;
  localparam int LO_W  = 22;
  localparam int TOT_W = MAG_W + VOL_W + 1;
  localparam logic [TOT_W-1:0] RND_HALF  = TOT_W'(64'd5 << 30);
  localparam logic [17:0]      Q_LIMIT   = 18'd163845;
  localparam logic [23:0]      RECIP5    = 24'd13421773;

  // Taylor term divisors 6, 20, 42, 72, 110, 156, 210 as reciprocals,
  // exact for terms below 2^34
  localparam int TAY_SH = 42;
  localparam logic [63:0] TAY_RCP [7] = '{
    ((64'd1 << TAY_SH) / 64'd6) + 64'd1,
    ((64'd1 << TAY_SH) / 64'd20) + 64'd1,
    ((64'd1 << TAY_SH) / 64'd42) + 64'd1,
    ((64'd1 << TAY_SH) / 64'd72) + 64'd1,
    ((64'd1 << TAY_SH) / 64'd110) + 64'd1,
    ((64'd1 << TAY_SH) / 64'd156) + 64'd1,
    ((64'd1 << TAY_SH) / 64'd210) + 64'd1
  };

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_SET  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_MAC  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_MLO  = 4'd6;
  localparam logic [3:0] S_MHI  = 4'd7;
  localparam logic [3:0] S_RND  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam logic [1:0] ENV_UP   = 2'd0;
  localparam logic [1:0] ENV_DOWN = 2'd1;
  localparam logic [1:0] ENV_FULL = 2'd2;
  localparam logic [1:0] ENV_ZERO = 2'd3;

  typedef logic [SMP_W-1:0] sine_rom_t [SINE_ENTRIES];

  function automatic sine_rom_t build_sine();
    sine_rom_t r;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    logic [127:0] tp;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      x = ((64'(2 * k + 1)) * HALF_PI_Q30) >> (IW + 1);
      t = x;
      s = x;
      for (int n = 3; n <= 15; n += 2) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        tp = 128'(t) * 128'(TAY_RCP[(n - 3) >> 1]);
        t = tp[TAY_SH +: 64];
        if (((n >> 1) & 1) == 1) s = s - t;
        else s = s + t;
      end
      e = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (e > 64'd32767) e = 64'd32767;
      r[k] = e[SMP_W-1:0];
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // voice state memories; valid bits stand for the reset contents
  logic [PHASE_W-1:0] phase_mem [VOICES];
  logic [STEP_W-1:0]  step_mem  [VOICES];
  logic [AGE_W-1:0]   age_mem   [VOICES];
  logic [VOICES-1:0]  vld;

  logic [3:0]         state;
  logic [VA-1:0]      vidx;
  logic [PHASE_W-1:0] rd_phase;
  logic [STEP_W-1:0]  rd_step;
  logic [AGE_W-1:0]   rd_age;
  logic               rd_vld;
  logic [PHASE_W-1:0] ph;
  logic [STEP_W-1:0]  stp;
  logic [AGE_W-1:0]   age;
  logic [1:0]         env_sel;
  logic [2:0]         hcnt;
  logic signed [W_W-1:0]   wsum;
  logic [ENV_W-1:0]        env;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;
  logic [MAG_W-1:0]        mag;
  logic                    neg;
  logic [TOT_W-1:0]        p_lo;
  logic [TOT_W-1:0]        total;
  logic [QUOT_W-1:0]       qv;
  logic                    big;

  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [LEN_W-1:0]   div_den;
  logic               div_done;
  logic [QUOT_W-1:0]  div_quot;

  logic [PHASE_W-1:0] eff_phase;
  logic [STEP_W-1:0]  eff_step;
  logic [AGE_W-1:0]   eff_age;
  logic [AGE_W-1:0]   att_ext;
  logic [AGE_W-1:0]   end_age;
  logic [1:0]         sel_next;
  logic [PHASE_W-1:0] hph;
  logic [IW-1:0]      sidx;
  logic [SMP_W-1:0]   sval;
  logic signed [W_W-1:0] sterm;
  logic [2:0]         hmul;
  logic [2:0]         hcoef;
  logic [ENV_W-1:0]   env_next;
  logic [TOT_W:0]     rnd_sum;
  logic [17:0]        yv;
  logic [41:0]        qprod;
  logic               clip_pos;
  logic               clip_neg;
  logic [SMP_W-1:0]   qsat;

  asvar_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign eff_phase = rd_vld ? rd_phase : '0;
  assign eff_step  = rd_vld ? rd_step  : '0;
  assign eff_age   = rd_vld ? rd_age   : AGE_SILENT;
  assign att_ext   = {1'b0, cfg.attack_len};
  assign end_age   = att_ext + {1'b0, cfg.decay_len};

  // classify the envelope segment and set up the division for it
  always_comb begin
    div_num  = '0;
    div_den  = 15'd1;
    sel_next = ENV_ZERO;
    if ((cfg.attack_len != '0) && (eff_age <= att_ext)) begin
      sel_next = ENV_UP;
      div_num  = {1'b0, eff_age, 15'd0};
      div_den  = cfg.attack_len;
    end else if ((eff_age > att_ext) && (eff_age < end_age)) begin
      sel_next = ENV_DOWN;
      div_num  = {1'b0, eff_age - att_ext, 15'd0};
      div_den  = cfg.decay_len;
    end else if ((cfg.attack_len == '0) && (eff_age == '0) && (cfg.decay_len != '0)) begin
      sel_next = ENV_FULL;
    end
  end

  assign div_start = (state == S_SET);

  // harmonic lookup: phase times 1, 3, 5, 7 with weights 5, 3, 2, 1
  always_comb begin
    unique case (hcnt[1:0])
      2'd0: begin hmul = 3'd1; hcoef = 3'd5; end
      2'd1: begin hmul = 3'd3; hcoef = 3'd3; end
      2'd2: begin hmul = 3'd5; hcoef = 3'd2; end
      default: begin hmul = 3'd7; hcoef = 3'd1; end
    endcase
  end

  assign hph   = ph * PHASE_W'(hmul);
  assign sidx  = hph[30] ? ~hph[29 -: IW] : hph[29 -: IW];
  assign sval  = SINE_ROM[sidx];
  assign sterm = hph[31] ? -(W_W'(hcoef) * W_W'(sval)) : (W_W'(hcoef) * W_W'(sval));

  always_comb begin
    unique case (env_sel)
      ENV_UP:   env_next = div_quot;
      ENV_DOWN: env_next = ENV_ONE - div_quot;
      ENV_FULL: env_next = ENV_ONE;
      default:  env_next = '0;
    endcase
  end

  // the limit is 5 * 32769: anything at or above it clips on either side
  assign rnd_sum  = {1'b0, total} + {1'b0, RND_HALF};
  assign yv       = (rnd_sum[TOT_W:31] >= (TOT_W-30)'(Q_LIMIT)) ? Q_LIMIT
                    : rnd_sum[48:31];
  assign qprod    = 42'(yv) * 42'(RECIP5);
  assign clip_pos = !neg && (big || (qv > 17'd32767));
  assign clip_neg = neg && (big || (qv > 17'd32768));
  assign qsat     = clip_pos ? 16'h7FFF : clip_neg ? 16'h8000
                    : (neg ? 16'(-qv) : qv[SMP_W-1:0]);
  assign q_pop    = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_phase <= phase_mem[vidx];
      rd_step  <= step_mem[vidx];
      rd_age   <= age_mem[vidx];
    end
    if (q_pop && q_item.is_note) begin
      phase_mem[q_item.voice[VA-1:0]] <= '0;
      step_mem[q_item.voice[VA-1:0]]  <= q_item.step;
      age_mem[q_item.voice[VA-1:0]]   <= '0;
    end else if (state == S_ACC) begin
      phase_mem[vidx] <= ph + PHASE_W'(stp);
      step_mem[vidx]  <= stp;
      age_mem[vidx]   <= (age == AGE_SILENT) ? age : age + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_SET: begin
        ph      <= eff_phase;
        stp     <= eff_step;
        age     <= eff_age;
        env_sel <= sel_next;
        wsum    <= '0;
      end
      S_DIV: begin
        if (!hcnt[2]) wsum <= wsum + sterm;
        if (div_done) env <= env_next;
      end
      S_MAC: prod <= PW'(wsum) * $signed({1'b0, env});
      S_MLO: begin
        mag  <= acc[ACC_W-1] ? MAG_W'(-acc) : acc[MAG_W-1:0];
        neg  <= acc[ACC_W-1];
        p_lo <= TOT_W'(MAG_W'(acc[ACC_W-1] ? -acc : acc) & MAG_W'(2**LO_W - 1)) * TOT_W'(cfg.volume);
      end
      S_MHI: total <= ((TOT_W'(mag >> LO_W) * TOT_W'(cfg.volume)) << LO_W) + p_lo;
      S_RND: begin
        big <= (yv == Q_LIMIT);
        qv  <= {1'b0, qprod[42-1:26]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      vld         <= '0;
      vidx        <= '0;
      hcnt        <= '0;
      acc         <= '0;
      out_valid   <= 1'b0;
      out_sample  <= '0;
      out_clipped <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.is_note) begin
              vld[q_item.voice[VA-1:0]] <= 1'b1;
            end else begin
              acc   <= '0;
              vidx  <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          rd_vld <= vld[vidx];
          state  <= S_SET;
        end
        S_SET: begin
          hcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!hcnt[2]) hcnt <= hcnt + 3'd1;
          if (div_done) state <= S_MAC;
        end
        S_MAC: state <= S_ACC;
        S_ACC: begin
          acc       <= acc + ACC_W'(prod);
          vld[vidx] <= 1'b1;
          if (32'(vidx) == VOICES - 1) begin
            state <= S_MLO;
          end else begin
            vidx  <= vidx + VA'(1);
            state <= S_READ;
          end
        end
        S_MLO: state <= S_MHI;
        S_MHI: state <= S_RND;
        S_RND: state <= S_OUT;
        S_OUT: begin
          // hold until the output register is free; a transfer taken this
          // cycle frees it
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            out_sample  <= qsat;
            out_clipped <= clip_pos || clip_neg;
            state       <= S_IDLE;
          end else begin
            out_valid   <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/additive_synth_voices_ar_envelope.sv =====
// Top level of the additive synth voice block: APB registers, front queue, back end.
// Depends on asvar_pkg, asvar_front, asvar_back, asvar_div.
//
// Usage:
//  - Input stream (s_*): tuser selects the kind of transfer, 0 asks for one
//    output sample, 1 is a note hit that loads a voice's phase step and restarts
//    its phase and age. Note hits on a voice beyond the last are dropped.
//  - Output stream (m_*): one transfer per sample request; tdata is the signed
//    16-bit mix, tuser flags that the mix saturated. Note hits give nothing.
//  - APB port: attack length (0x0), decay length (0x4), master volume (0x8).
//    Write only while the block is idle.
// Timing:
//  - An accepted transfer reaches the back end through the registered
//    queue. A note hit is applied in the cycle the back end pops it.
//  - For each voice of a sample the back end reads the voice state, sets up
//    the bit-serial envelope divider, runs the harmonic lookups during the
//    division, then multiplies and accumulates; scaling, rounding and output
//    follow after the last voice.
//  - A two-entry queue keeps accepting while the back end works or while a
//    finished sample waits; a stalled receiver holds the back end in its
//    last step and then backs up the queue and s_tready.
// Reset: synchronous; all voices go silent, registers return to 3000, 4000, 0.
module additive_synth_voices_ar_envelope import asvar_pkg::*; #(
  parameter int VOICES       = 16,
  parameter int SINE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [3:0] voice, [33:4] phase_step, rest zero
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample_out
  output logic        m_tuser,   // [0] clipped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  logic        cfg_wr;
  logic        q_valid;
  logic        q_pop;
  queue_item_t q_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_len <= 15'd3000;
      cfg.decay_len  <= 15'd4000;
      cfg.volume     <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ATTACK: cfg.attack_len <= pwdata[LEN_W-1:0];
        REG_DECAY:  cfg.decay_len  <= pwdata[LEN_W-1:0];
        REG_VOLUME: cfg.volume     <= pwdata[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ATTACK: prdata = 32'(cfg.attack_len);
      REG_DECAY:  prdata = 32'(cfg.decay_len);
      REG_VOLUME: prdata = 32'(cfg.volume);
      default:    prdata = '0;
    endcase
  end

  asvar_front #(.VOICES(VOICES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_func  (s_tuser),
    .in_voice (s_tdata[3:0]),
    .in_step  (s_tdata[33:4]),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  asvar_back #(.VOICES(VOICES), .SINE_ENTRIES(SINE_ENTRIES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_sample  (m_tdata),
    .out_clipped (m_tuser)
  );

endmodule

// ===== tb/sv/tb_additive_synth_voices_ar_envelope.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for additive_synth_voices_ar_envelope: note hits and
// sample requests over the stream ports, envelope and volume over APB.
// Depends on asvar_pkg and the block's RTL.
module tb_additive_synth_voices_ar_envelope;
  import asvar_pkg::*;

  localparam int NVOICE    = 16;
  localparam int NSINE     = 256;
  localparam int HOLD_LEN  = 3000;   // long receiver hold-off, in cycles
  localparam int IDLE_MAX  = 20000;  // watchdog: cycles without any transfer
  localparam int SAMPLE_CY = 37 * NVOICE + 5;

  typedef struct {
    logic              func;
    logic [VSEL_W-1:0] voice;
    logic [STEP_W-1:0] step;
  } synth_cmd_t;

  typedef struct {
    logic [SMP_W-1:0] smp;
    logic             clip;
  } mix_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // [3:0] voice, [33:4] phase_step, rest zero
  logic        s_tuser = 1'b0;  // [0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;  // [15:0] sample_out
  logic        m_tuser;  // [0] clipped
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  additive_synth_voices_ar_envelope dut (.*);

  always #5 clk = ~clk;

  // predictor state
  int unsigned   sine_lut [NSINE];
  logic [31:0]   phase_acc [NVOICE];
  logic [29:0]   phase_inc [NVOICE];
  logic [15:0]   note_age [NVOICE];
  longint        atk_len = 3000;
  longint        dec_len = 4000;
  longint        master_vol = 0;

  synth_cmd_t    pending_cmds[$];
  mix_result_t   expected_mix[$];
  int            errors = 0;
  int            idle_cycles = 0;
  bit            hold_req = 1'b0;
  bit            hold_done = 1'b0;
  int            hold_cnt = 0;
  int            gap_cnt = 0;

  // quarter-wave table by truncating Q30 Taylor series
  task automatic build_sine_lut();
    longint unsigned x, t, s, e;
    for (int k = 0; k < NSINE; k++) begin
      x = ((2 * k + 1) * HALF_PI_Q30) / (2 * NSINE);
      t = x;
      s = x;
      for (int n = 3; n <= 15; n += 2) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / ((n - 1) * n);
        if ((n >> 1) & 1) s = s - t;
        else s = s + t;
      end
      e = (s * 32767 + (64'd1 << 29)) >> 30;
      if (e > 32767) e = 32767;
      sine_lut[k] = 32'(e);
    end
  endtask

  function automatic longint tone_sine(logic [31:0] ph);
    longint unsigned idx;
    idx = ({34'd0, ph[29:0]} * NSINE) >> 30;
    if (idx >= NSINE) idx = NSINE - 1;
    if (ph[30]) idx = NSINE - 1 - idx;
    return ph[31] ? -longint'(sine_lut[idx]) : longint'(sine_lut[idx]);
  endfunction

  function automatic longint env_level(longint age);
    if (atk_len > 0 && age <= atk_len) return (age * 32768) / atk_len;
    if (age > atk_len && age < atk_len + dec_len)
      return 32768 - ((age - atk_len) * 32768) / dec_len;
    if (atk_len == 0 && age == 0 && dec_len > 0) return 32768;
    return 0;
  endfunction

  // one sample: sum all voices, advance them, scale and saturate
  function automatic mix_result_t mix_sample();
    mix_result_t r;
    longint acc, w, total;
    longint unsigned mag, q;
    logic [31:0] ph;
    acc = 0;
    r.clip = 1'b0;
    for (int v = 0; v < NVOICE; v++) begin
      ph = phase_acc[v];
      w = 5 * tone_sine(ph) + 3 * tone_sine(ph * 32'd3) + 2 * tone_sine(ph * 32'd5)
          + tone_sine(ph * 32'd7);
      acc += w * env_level(longint'(note_age[v]));
      phase_acc[v] = ph + {2'b00, phase_inc[v]};
      if (note_age[v] != AGE_SILENT) note_age[v] = note_age[v] + 16'd1;
    end
    total = acc * master_vol;
    mag = (total < 0) ? longint'(-total) : total;
    q = (mag + (64'd5 << 30)) / (64'd5 << 31);
    if (total < 0) begin
      if (q > 32768) begin
        q = 32768;
        r.clip = 1'b1;
      end
      r.smp = -q[15:0];
    end else begin
      if (q > 32767) begin
        q = 32767;
        r.clip = 1'b1;
      end
      r.smp = q[15:0];
    end
    return r;
  endfunction

  // Driver: predict on each accepted transfer, then offer the next command
  // after a random gap. Most gaps are short, one in ten is long.
  always @(posedge clk) begin
    synth_cmd_t c;
    logic       nvalid;
    nvalid = s_tvalid;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_NOTE) begin
          phase_inc[s_tdata[3:0]] = s_tdata[33:4];
          phase_acc[s_tdata[3:0]] = '0;
          note_age[s_tdata[3:0]]  = '0;
        end else begin
          expected_mix = {expected_mix, mix_sample()};
        end
        nvalid = 1'b0;
        case ($urandom_range(0, 9))
          0:       gap_cnt = $urandom_range(10, 60);
          1, 2, 3: gap_cnt = $urandom_range(1, 3);
          default: gap_cnt = 0;
        endcase
      end
      if (!nvalid) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          s_tuser <= c.func;
          s_tdata <= {6'd0, c.step, c.voice};
          nvalid = 1'b1;
        end
      end
      s_tvalid <= nvalid;
    end
  end

  // Monitor: compare each result with the oldest expectation; stall the
  // receiver at random, and once hold off long enough to back up the input.
  always @(posedge clk) begin
    mix_result_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_mix.size() == 0) begin
          $display("%0t: unexpected result sample=%0d clipped=%0b", $time,
                   $signed(m_tdata), m_tuser);
          errors++;
        end else begin
          e = expected_mix.pop_front();
          if (m_tdata !== e.smp || m_tuser !== e.clip) begin
            $display("%0t: mismatch expected sample=%0d clipped=%0b actual sample=%0d clipped=%0b",
                     $time, $signed(e.smp), e.clip, $signed(m_tdata), m_tuser);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_cnt++;
        if (hold_cnt >= HOLD_LEN) hold_done = 1'b1;
        m_tready <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0:       m_tready <= 1'b0;
          1, 2:    m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= 1'b1;
        endcase
      end
    end
  end

  // Watchdog: count cycles with no transfer on either stream
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("tb_additive_synth_voices_ar_envelope failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // APB write: setup, access, then drop select; mirror into the predictor
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ATTACK: atk_len = val[14:0];
      REG_DECAY:  dec_len = val[14:0];
      REG_VOLUME: master_vol = val[15:0];
      default: ;
    endcase
  endtask

  task automatic add_cmd(logic func, logic [3:0] voice, logic [29:0] step);
    synth_cmd_t c;
    c.func  = func;
    c.voice = voice;
    c.step  = step;
    pending_cmds = {pending_cmds, c};
  endtask

  // Wait until every command went in and every sample came back, then let
  // a trailing note hit finish in the back end. Check between edges so the
  // driver's updates have settled.
  task automatic drain();
    while (pending_cmds.size() > 0 || s_tvalid || expected_mix.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic config_phase(int atk, int dec, int vol);
    reg_write(REG_ATTACK, atk);
    reg_write(REG_DECAY, dec);
    reg_write(REG_VOLUME, vol);
  endtask

  // Random phase: a little under half note hits, the rest sample requests; half
  // of the hits use short steps for steady tones, the others full-width steps so every step bit toggles.
  task automatic random_phase(int n);
    logic [29:0] st;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 48) begin
        st = ($urandom_range(0, 1)) ? 30'($urandom())
             : 30'($urandom_range(0, 32'h00FF_FFFF));
        add_cmd(FUNC_NOTE, 4'($urandom_range(0, NVOICE - 1)), st);
      end else begin
        add_cmd(FUNC_SAMPLE, 4'd0, '0);
      end
    end
    drain();
  endtask

  initial begin
    build_sine_lut();
    for (int v = 0; v < NVOICE; v++) begin
      phase_acc[v] = '0;
      phase_inc[v] = '0;
      note_age[v]  = AGE_SILENT;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset config, zero volume: silent output from idle voices and after a note hit
    add_cmd(FUNC_SAMPLE, 4'd0, '0);
    add_cmd(FUNC_NOTE, 4'd0, 30'h3FFF_FFFF);
    add_cmd(FUNC_SAMPLE, 4'd0, '0);
    drain();

    // full volume, zero attack: the hit voices start at full level
    config_phase(0, 20, 65535);
    add_cmd(FUNC_SAMPLE, 4'd0, '0);
    add_cmd(FUNC_NOTE, 4'd0, '0);
    add_cmd(FUNC_NOTE, 4'd15, 30'h3FFF_FFFF);
    add_cmd(FUNC_NOTE, 4'd7, 30'h0100_0000);
    for (int i = 0; i < 4; i++) add_cmd(FUNC_SAMPLE, 4'd0, '0);
    drain();

    // zero decay: level drops to nothing after the attack
    config_phase(3, 0, 65535);
    for (int v = 0; v < NVOICE; v++) add_cmd(FUNC_NOTE, 4'(v), 30'h0040_0000);
    for (int i = 0; i < 6; i++) add_cmd(FUNC_SAMPLE, 4'd0, '0);
    drain();

    // widest lengths, all voices hit; the sample at age zero has zero attack level
    config_phase(32767, 32767, 65535);
    for (int v = 0; v < NVOICE; v++) add_cmd(FUNC_NOTE, 4'(v), '0);
    add_cmd(FUNC_SAMPLE, 4'd0, '0);
    drain();

    // random phases; the first one carries the long receiver hold-off
    hold_req = 1'b1;
    config_phase(3000, 4000, $urandom_range(20000, 65535));
    random_phase(380);
    config_phase(20, 20, 65535);
    random_phase(380);
    config_phase(0, 50, $urandom_range(0, 65535));
    random_phase(380);
    config_phase(100, 0, 65535);
    random_phase(380);
    config_phase(20020, 20020, $urandom_range(0, 65535));
    random_phase(380);

    repeat (SAMPLE_CY) @(posedge clk);
    if (errors == 0 && expected_mix.size() == 0) begin
      $display("tb_additive_synth_voices_ar_envelope passed");
    end else begin
      $display("tb_additive_synth_voices_ar_envelope failed");
    end
    $finish;
  end

endmodule
